@@ sv/exception_table_varint_decoder_macros.svh @@
// Assertion helpers for the exception table decoder.
`ifndef EXCEPTION_TABLE_VARINT_DECODER_MACROS_SVH
`define EXCEPTION_TABLE_VARINT_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ETVD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ETVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/etvd_pkg.sv @@
package etvd_pkg;

    // default accumulator width
    localparam int VALUE_BITS_DEF = 30;

    // varint byte layout
    localparam int PAYLOAD_BITS = 6;
    localparam int MORE_BIT     = 6;

    // entry field positions
    localparam logic [1:0] FLD_START  = 2'd0;
    localparam logic [1:0] FLD_LENGTH = 2'd1;
    localparam logic [1:0] FLD_TARGET = 2'd2;
    localparam logic [1:0] FLD_DEPTH  = 2'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_OVF   = 2'd2
    } status_t;

    typedef struct packed {
        logic        push_lasti;
        logic [28:0] stack_depth;
        logic [30:0] handler_target;
        logic [31:0] range_end;
        logic [30:0] range_start;
        status_t     status;
    } result_t;

endpackage

@@ sv/exception_table_varint_decoder.sv @@
// Exception table varint decoder, one table byte per transaction.
// A result is registered on m_* from the byte that completes it, or held in the skid stage while m_* stalls.
// Throughput: one byte per cycle while the skid stage is empty; the accumulate/shift step and field counter
// are combinational, and a two-deep output (register plus skid) absorbs stalls.
// Reset (aresetn low, synchronous): decode state, field counter and both
// output valids clear; result payload registers are not reset.
`include "exception_table_varint_decoder_macros.svh"

module exception_table_varint_decoder #(
    parameter int VALUE_BITS = etvd_pkg::VALUE_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // slave side
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] table_byte
    input  logic         s_tlast,   // end_of_table
    // master side
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [30:0] range_start, [62:31] range_end,
                                    // [93:63] handler_target, [122:94] stack_depth,
                                    // [123] push_lasti, [127:124] zero
    output logic [1:0]   m_tuser    // [1:0] status
);

    import etvd_pkg::*;

    // decode state
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [1:0]            field_idx_reg, field_idx_next;
    logic [VALUE_BITS-1:0] saved_start_reg, saved_start_next;
    logic [VALUE_BITS-1:0] saved_length_reg, saved_length_next;
    logic [VALUE_BITS-1:0] saved_target_reg, saved_target_next;
    logic                  ovf_reg, ovf_next;

    // output register and skid stage
    logic    m_valid_reg, m_valid_next;
    result_t m_data_reg, m_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    logic                  s_acc;
    logic                  more;
    logic [VALUE_BITS-1:0] acc_or;
    logic                  ovf_hit;
    logic                  entry_done;
    logic                  mid_after;
    logic                  res_trunc;
    logic                  res_fire;
    logic [31:0]           start_x2;
    logic [31:0]           length_x2;
    logic [31:0]           target_x2;
    result_t               res;

    assign s_tready = !skid_valid_reg;
    assign s_acc    = s_tvalid && s_tready;

    // merge payload bits and test for overflow before the continuation shift
    assign more    = s_tdata[MORE_BIT];
    assign acc_or  = acc_reg | VALUE_BITS'(s_tdata[PAYLOAD_BITS-1:0]);
    assign ovf_hit = |(acc_or >> (VALUE_BITS - PAYLOAD_BITS));

    assign entry_done = !more && (field_idx_reg == FLD_DEPTH);
    assign mid_after  = more || (field_idx_reg != FLD_DEPTH);
    assign res_trunc  = s_tlast && !entry_done && mid_after;
    assign res_fire   = entry_done || res_trunc;

    // result fields
    assign start_x2  = 32'(saved_start_reg) << 1;
    assign length_x2 = 32'(saved_length_reg) << 1;
    assign target_x2 = 32'(saved_target_reg) << 1;

    always_comb begin
        res = '0;
        if (res_trunc) begin
            res.status = ST_TRUNC;
        end else if (ovf_reg) begin
            res.status = ST_OVF;
        end else begin
            res.status         = ST_OK;
            res.range_start    = start_x2[30:0];
            res.range_end      = start_x2 + length_x2;
            res.handler_target = target_x2[30:0];
            res.stack_depth    = 29'(acc_or >> 1);
            res.push_lasti     = acc_or[0];
        end
    end

    // decode state update
    always_comb begin
        acc_next          = acc_reg;
        field_idx_next    = field_idx_reg;
        saved_start_next  = saved_start_reg;
        saved_length_next = saved_length_reg;
        saved_target_next = saved_target_reg;
        ovf_next          = ovf_reg;
        if (s_acc) begin
            if (s_tlast) begin
                acc_next          = '0;
                field_idx_next    = FLD_START;
                saved_start_next  = '0;
                saved_length_next = '0;
                saved_target_next = '0;
                ovf_next          = 1'b0;
            end else if (more) begin
                acc_next = acc_or << PAYLOAD_BITS;
                ovf_next = ovf_reg | ovf_hit;
            end else begin
                acc_next       = '0;
                field_idx_next = field_idx_reg + 2'd1;
                case (field_idx_reg)
                    FLD_START:  saved_start_next  = acc_or;
                    FLD_LENGTH: saved_length_next = acc_or;
                    FLD_TARGET: saved_target_next = acc_or;
                    default:    ovf_next          = 1'b0;
                endcase
            end
        end
    end

    // output register with skid stage behind it
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (s_acc && res_fire) begin
                m_valid_next = 1'b1;
                m_data_next  = res;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (s_acc && res_fire) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg          <= '0;
            field_idx_reg    <= FLD_START;
            saved_start_reg  <= '0;
            saved_length_reg <= '0;
            saved_target_reg <= '0;
            ovf_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            acc_reg          <= acc_next;
            field_idx_reg    <= field_idx_next;
            saved_start_reg  <= saved_start_next;
            saved_length_reg <= saved_length_next;
            saved_target_reg <= saved_target_next;
            ovf_reg          <= ovf_next;
            m_valid_reg      <= m_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg.push_lasti, m_data_reg.stack_depth,
                       m_data_reg.handler_target, m_data_reg.range_end,
                       m_data_reg.range_start};
    assign m_tuser  = m_data_reg.status;

    // checks
    `ETVD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_valid_reg,
        "skid stage holds a result while output register is empty")
    `ETVD_ASSERT_NEXT(a_last_clears_state, s_acc && s_tlast,
        (field_idx_reg == FLD_START) && (acc_reg == '0) && !ovf_reg,
        "decode state not cleared after end of table")
    `ETVD_ASSERT_NEXT(a_stalled_result_kept, m_valid_reg && !m_tready && s_acc && res_fire,
        skid_valid_reg && m_valid_reg,
        "result lost while output stalled")
    `ETVD_ASSERT_NOW(a_error_zero_payload,
        m_valid_reg && (m_data_reg.status != ST_OK), m_tdata == '0,
        "error result carries nonzero payload")

endmodule
